[rtl/mvs_pkg.sv]
// Package for the multilinear vertex synthesis block.
// Holds sizes, request codes, payload structs, the sequencer state type and rounding helpers.
// No dependencies.
package mvs_pkg;

    localparam int IdCount     = 16;
    localparam int ExpCount    = 8;
    localparam int VertexCount = 256;
    localparam int MixLen      = IdCount * ExpCount;
    localparam int CoreRows    = 3 * VertexCount;
    localparam int IdW   = $clog2(IdCount);
    localparam int ExW   = $clog2(ExpCount);
    localparam int MixW  = $clog2(MixLen);
    localparam int VtxW  = $clog2(VertexCount);
    localparam int CoreW = $clog2(CoreRows * MixLen);
    localparam int AccW  = 64;

    localparam logic [2:0] REQ_ID_BASIS  = 3'd0;
    localparam logic [2:0] REQ_EXP_BASIS = 3'd1;
    localparam logic [2:0] REQ_CORE      = 3'd2;
    localparam logic [2:0] REQ_ID_WEIGHT = 3'd3;
    localparam logic [2:0] REQ_EX_WEIGHT = 3'd4;
    localparam logic [2:0] REQ_VERTEX    = 3'd5;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [9:0]         row_index;
        logic [6:0]         col_index;
        logic signed [23:0] value;
        logic               brute_identity;
        logic               brute_expression;
        logic [7:0]         vertex_index;
    } t_in;

    typedef struct packed {
        logic [7:0]         vertex_number;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ID_ROW,
        ST_EX_ROW,
        ST_MIX,
        ST_DOT,
        ST_DONE
    } t_state;

    // Round half up at bit 16 (arithmetic shift is a floor).
    function automatic logic signed [AccW-1:0] round16(input logic signed [AccW-1:0] a);
        logic signed [AccW-1:0] t;
        begin
            t = a + 64'sd32768;
            return t >>> 16;
        end
    endfunction

    function automatic logic signed [23:0] to_q24(input logic signed [AccW-1:0] a);
        logic signed [AccW-1:0] r;
        begin
            r = round16(a);
            if (r > 64'sd8388607) return 24'sh7fffff;
            if (r < -64'sd8388608) return 24'sh800000;
            return r[23:0];
        end
    endfunction

    function automatic logic signed [31:0] to_q32(input logic signed [AccW-1:0] a);
        logic signed [AccW-1:0] r;
        begin
            r = round16(a);
            if (r > 64'sd2147483647) return 32'sh7fffffff;
            if (r < -64'sd2147483648) return 32'sh80000000;
            return r[31:0];
        end
    endfunction

endpackage

[rtl/multilinear_vertex_synthesis.sv]
// Top level of the multilinear vertex synthesis block.
// Uses mvs_pkg for sizes, codes, payload structs and rounding functions.
// Holds all tables as internal memories and one shared multiply-accumulate sequencer.

// A vertex request is accepted in one transfer. Its identity row is formed from 256 products,
// its expression row from 64, its mixing vector from 128 and its three coordinate dot products
// from 384, and the multiplier pipeline drains after each phase before the next one issues.
// The finished result then moves to the output register. A brute identity request skips the
// identity row, a brute expression request skips the expression row, and a request with both
// set skips both. A single shared 24x24 multiplier forms, one product a cycle while a phase
// issues, the identity row, the expression row, the mixing vector and then the three
// coordinate dot products, reading the core table through one port. Write transfers give no
// result. A request whose vertex index is out of range, and an unused request code, give no
// result. The block is not ready while a request is in progress. A finished result waits in
// the output register, so table writes and the next request are accepted while it waits; a
// request that finishes while the previous result is still waiting holds its result back,
// still not ready, until the output register is taken. All tables are undefined until
// written; there is no clearing pass after reset.
module multilinear_vertex_synthesis (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mvs_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output mvs_pkg::t_out  o_data
);

    logic signed [23:0] r_id_basis [mvs_pkg::IdCount*mvs_pkg::IdCount];
    logic signed [23:0] r_ex_basis [mvs_pkg::ExpCount*mvs_pkg::ExpCount];
    logic signed [23:0] r_core     [mvs_pkg::CoreRows*mvs_pkg::MixLen];
    logic signed [23:0] r_id_w     [mvs_pkg::IdCount];
    logic signed [23:0] r_ex_w     [mvs_pkg::ExpCount];
    logic signed [23:0] r_id_row   [mvs_pkg::IdCount];
    logic signed [23:0] r_ex_row   [mvs_pkg::ExpCount];
    logic signed [23:0] r_mix      [mvs_pkg::MixLen];

    mvs_pkg::t_state r_state, n_state;
    logic [7:0]  r_i, r_j;          // inner (sum) index and outer (output) index
    logic [1:0]  r_c;               // coordinate in the dot phase
    logic        r_bid, r_bex;
    logic [7:0]  r_vtx;
    logic signed [mvs_pkg::AccW-1:0] r_acc;
    logic signed [23:0] r_a, r_b;   // registered operands of the shared multiplier
    logic signed [47:0] r_prod;
    logic        r_pv, r_mv;        // operand and product valid
    logic        r_plast, r_mlast;  // marks the last term of a sum
    logic        r_out_valid;
    logic signed [31:0] r_cx, r_cy, r_cz;  // coordinates of the request in progress
    mvs_pkg::t_out r_out;

    logic in_xfer, out_xfer, res_load, last_term, phase_end;

    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = r_out_valid && i_ready;
    // The finished result moves to the output register when that register is empty or is
    // being emptied by a transfer in the same cycle.
    assign res_load = (r_state == mvs_pkg::ST_DONE) && (!r_out_valid || i_ready);
    assign o_ready  = (r_state == mvs_pkg::ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    // Table writes.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            unique case (i_data.req_type)
                mvs_pkg::REQ_ID_BASIS:
                    if (i_data.row_index < 10'(mvs_pkg::IdCount) &&
                        i_data.col_index < 7'(mvs_pkg::IdCount))
                        r_id_basis[{i_data.row_index[mvs_pkg::IdW-1:0],
                                    i_data.col_index[mvs_pkg::IdW-1:0]}] <= i_data.value;
                mvs_pkg::REQ_EXP_BASIS:
                    if (i_data.row_index < 10'(mvs_pkg::ExpCount) &&
                        i_data.col_index < 7'(mvs_pkg::ExpCount))
                        r_ex_basis[{i_data.row_index[mvs_pkg::ExW-1:0],
                                    i_data.col_index[mvs_pkg::ExW-1:0]}] <= i_data.value;
                mvs_pkg::REQ_CORE:
                    if (i_data.row_index < 10'(mvs_pkg::CoreRows))
                        r_core[{i_data.row_index, i_data.col_index}] <= i_data.value;
                mvs_pkg::REQ_ID_WEIGHT:
                    if (i_data.col_index < 7'(mvs_pkg::IdCount))
                        r_id_w[i_data.col_index[mvs_pkg::IdW-1:0]] <= i_data.value;
                mvs_pkg::REQ_EX_WEIGHT:
                    if (i_data.col_index < 7'(mvs_pkg::ExpCount))
                        r_ex_w[i_data.col_index[mvs_pkg::ExW-1:0]] <= i_data.value;
                default: ;
            endcase
        end
    end

    // Operand index counters: r_i runs over terms, r_j over outputs, r_c over coordinates.
    always_comb begin
        unique case (r_state)
            mvs_pkg::ST_ID_ROW: last_term = (r_i == 8'(mvs_pkg::IdCount - 1));
            mvs_pkg::ST_EX_ROW: last_term = (r_i == 8'(mvs_pkg::ExpCount - 1));
            mvs_pkg::ST_DOT:    last_term = (r_i == 8'(mvs_pkg::MixLen - 1));
            default:            last_term = 1'b1;
        endcase
    end

    always_comb begin
        unique case (r_state)
            mvs_pkg::ST_ID_ROW: phase_end = last_term && (r_j == 8'(mvs_pkg::IdCount - 1));
            mvs_pkg::ST_EX_ROW: phase_end = last_term && (r_j == 8'(mvs_pkg::ExpCount - 1));
            mvs_pkg::ST_MIX:    phase_end = (r_j == 8'(mvs_pkg::MixLen - 1));
            mvs_pkg::ST_DOT:    phase_end = last_term && (r_c == 2'd2);
            default:            phase_end = 1'b0;
        endcase
    end

    // The pipeline drains (r_pv, r_mv clear) before the next phase issues, so each
    // phase reads only values that the previous phase has finished writing.
    logic drained;
    assign drained = !r_pv && !r_mv;

    logic [9:0] core_row;
    assign core_row = 10'({2'b00, r_vtx} * 10'd3) + 10'(r_c);

    logic issue;
    logic r_wait;   // set while waiting for the pipeline to drain between phases

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mvs_pkg::ST_IDLE:
                if (in_xfer && i_data.req_type == mvs_pkg::REQ_VERTEX &&
                    32'(i_data.vertex_index) < mvs_pkg::VertexCount)
                    n_state = i_data.brute_identity ?
                        (i_data.brute_expression ? mvs_pkg::ST_MIX : mvs_pkg::ST_EX_ROW)
                        : mvs_pkg::ST_ID_ROW;
            mvs_pkg::ST_ID_ROW:
                if (r_wait && drained) n_state = r_bex ? mvs_pkg::ST_MIX : mvs_pkg::ST_EX_ROW;
            mvs_pkg::ST_EX_ROW:
                if (r_wait && drained) n_state = mvs_pkg::ST_MIX;
            mvs_pkg::ST_MIX:
                if (r_wait && drained) n_state = mvs_pkg::ST_DOT;
            mvs_pkg::ST_DOT:
                if (r_wait && drained) n_state = mvs_pkg::ST_DONE;
            mvs_pkg::ST_DONE:
                if (res_load) n_state = mvs_pkg::ST_IDLE;
            default: n_state = mvs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        issue = 1'b0;
        unique case (r_state)
            mvs_pkg::ST_ID_ROW, mvs_pkg::ST_EX_ROW, mvs_pkg::ST_MIX, mvs_pkg::ST_DOT:
                issue = !r_wait;
            default: issue = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mvs_pkg::ST_IDLE;
            r_pv        <= 1'b0;
            r_mv        <= 1'b0;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= issue;
            r_mv    <= r_pv;
            if (r_state != n_state) r_wait <= 1'b0;
            else if (issue && phase_end) r_wait <= 1'b1;
            if (res_load) r_out_valid <= 1'b1;
            else if (out_xfer) r_out_valid <= 1'b0;
        end
    end

    // Counters and request fields.
    always_ff @(posedge i_clk) begin
        if (r_state == mvs_pkg::ST_IDLE) begin
            r_i <= '0;
            r_j <= '0;
            r_c <= '0;
            if (in_xfer) begin
                r_bid <= i_data.brute_identity;
                r_bex <= i_data.brute_expression;
                r_vtx <= i_data.vertex_index;
            end
        end else if (r_state != n_state) begin
            r_i <= '0;
            r_j <= '0;
            r_c <= '0;
        end else if (issue) begin
            if (r_state == mvs_pkg::ST_MIX) begin
                r_j <= r_j + 8'd1;
            end else if (last_term) begin
                r_i <= '0;
                r_j <= r_j + 8'd1;
                r_c <= r_c + 2'd1;
            end else begin
                r_i <= r_i + 8'd1;
            end
        end
    end

    // Operand fetch into the multiplier input registers (one read per table per cycle).
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_plast <= last_term;
            unique case (r_state)
                mvs_pkg::ST_ID_ROW: begin
                    r_a <= r_id_w[r_i[mvs_pkg::IdW-1:0]];
                    r_b <= r_id_basis[{r_i[mvs_pkg::IdW-1:0], r_j[mvs_pkg::IdW-1:0]}];
                end
                mvs_pkg::ST_EX_ROW: begin
                    r_a <= r_ex_w[r_i[mvs_pkg::ExW-1:0]];
                    r_b <= r_ex_basis[{r_i[mvs_pkg::ExW-1:0], r_j[mvs_pkg::ExW-1:0]}];
                end
                mvs_pkg::ST_MIX: begin
                    r_a <= r_bid ? r_id_w[r_j[mvs_pkg::MixW-1:mvs_pkg::ExW]]
                                 : r_id_row[r_j[mvs_pkg::MixW-1:mvs_pkg::ExW]];
                    r_b <= r_bex ? r_ex_w[r_j[mvs_pkg::ExW-1:0]]
                                 : r_ex_row[r_j[mvs_pkg::ExW-1:0]];
                end
                default: begin
                    r_a <= r_core[{core_row, r_i[mvs_pkg::MixW-1:0]}];
                    r_b <= r_mix[r_i[mvs_pkg::MixW-1:0]];
                end
            endcase
        end
    end

    // Shared multiplier and accumulator; the write-back follows the product in the next cycle.
    mvs_pkg::t_state r_wb_state;
    logic [7:0] r_wb_j, r_pj;
    logic [1:0] r_wb_c, r_pc;
    logic signed [mvs_pkg::AccW-1:0] sum;

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pj <= (r_state == mvs_pkg::ST_DOT) ? 8'(r_c) : r_j;
            r_pc <= r_c;
        end
        if (r_pv) begin
            r_prod     <= r_a * r_b;
            r_mlast    <= r_plast;
            r_wb_j     <= r_pj;
            r_wb_c     <= r_pc;
            r_wb_state <= r_state;
        end
    end

    assign sum = r_acc + mvs_pkg::AccW'(r_prod);

    always_ff @(posedge i_clk) begin
        if (r_state == mvs_pkg::ST_IDLE) begin
            r_acc <= '0;
        end else if (r_mv) begin
            r_acc <= r_mlast ? '0 : sum;
            if (r_mlast) begin
                unique case (r_wb_state)
                    mvs_pkg::ST_ID_ROW:
                        r_id_row[r_wb_j[mvs_pkg::IdW-1:0]] <= mvs_pkg::to_q24(sum);
                    mvs_pkg::ST_EX_ROW:
                        r_ex_row[r_wb_j[mvs_pkg::ExW-1:0]] <= mvs_pkg::to_q24(sum);
                    mvs_pkg::ST_MIX:
                        r_mix[r_wb_j[mvs_pkg::MixW-1:0]] <= mvs_pkg::to_q24(sum);
                    mvs_pkg::ST_DOT:
                        unique case (r_wb_c)
                            2'd0:    r_cx <= mvs_pkg::to_q32(sum);
                            2'd1:    r_cy <= mvs_pkg::to_q32(sum);
                            default: r_cz <= mvs_pkg::to_q32(sum);
                        endcase
                    default: ;
                endcase
            end
        end
    end

    // Loaded only when free or being emptied, so a waiting result is never lost.
    always_ff @(posedge i_clk) begin
        if (res_load)
            r_out <= '{vertex_number: r_vtx, coord_x: r_cx, coord_y: r_cy, coord_z: r_cz};
    end

`ifndef SYNTH
    // A result appears only when a request has just finished.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == mvs_pkg::ST_DONE)
        else $error("result without a finished request");
    // Nothing is accepted while a computation is in flight.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv || r_mv) |-> !o_ready)
        else $error("accepted during computation");
    // A phase never leaves with products still in the pipeline.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != mvs_pkg::ST_IDLE && r_state != mvs_pkg::ST_DONE &&
         n_state != r_state) |-> drained)
        else $error("phase ended with work pending");
`endif

endmodule
